// ----- rtl/des_cbc_cipher_top_defines.svh -----
// assertion macros for the des cbc cipher block
// used by the top level
`ifndef DES_CBC_CIPHER_TOP_DEFINES_SVH
`define DES_CBC_CIPHER_TOP_DEFINES_SVH
`define DCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ----- rtl/dcc_pkg.sv -----
// shared types, tables and functions for the des cbc cipher
// no dependencies
`default_nettype none
package dcc_pkg;
	localparam int unsigned BlkW = 64;
	localparam int unsigned KeyW = 48;
	localparam int unsigned Rounds = 16;
	localparam int unsigned RndW = $clog2(Rounds);

	typedef enum logic [1:0] {
		CfgMode = 2'd0,
		CfgKey  = 2'd1,
		CfgIv   = 2'd2
	} cfg_idx_t;

	typedef logic [5:0] ptab_t [64];

	localparam ptab_t TabIp = '{
		6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,6'd9,6'd1,
		6'd59,6'd51,6'd43,6'd35,6'd27,6'd19,6'd11,6'd3,
		6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,6'd13,6'd5,
		6'd63,6'd55,6'd47,6'd39,6'd31,6'd23,6'd15,6'd7,
		6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8,6'd0,
		6'd58,6'd50,6'd42,6'd34,6'd26,6'd18,6'd10,6'd2,
		6'd60,6'd52,6'd44,6'd36,6'd28,6'd20,6'd12,6'd4,
		6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,6'd14,6'd6};
	localparam ptab_t TabFp = '{
		6'd39,6'd7,6'd47,6'd15,6'd55,6'd23,6'd63,6'd31,
		6'd38,6'd6,6'd46,6'd14,6'd54,6'd22,6'd62,6'd30,
		6'd37,6'd5,6'd45,6'd13,6'd53,6'd21,6'd61,6'd29,
		6'd36,6'd4,6'd44,6'd12,6'd52,6'd20,6'd60,6'd28,
		6'd35,6'd3,6'd43,6'd11,6'd51,6'd19,6'd59,6'd27,
		6'd34,6'd2,6'd42,6'd10,6'd50,6'd18,6'd58,6'd26,
		6'd33,6'd1,6'd41,6'd9,6'd49,6'd17,6'd57,6'd25,
		6'd32,6'd0,6'd40,6'd8,6'd48,6'd16,6'd56,6'd24};
	localparam logic [5:0] TabE [48] = '{
		6'd31,6'd0,6'd1,6'd2,6'd3,6'd4, 6'd3,6'd4,6'd5,6'd6,6'd7,6'd8,
		6'd7,6'd8,6'd9,6'd10,6'd11,6'd12, 6'd11,6'd12,6'd13,6'd14,6'd15,6'd16,
		6'd15,6'd16,6'd17,6'd18,6'd19,6'd20, 6'd19,6'd20,6'd21,6'd22,6'd23,6'd24,
		6'd23,6'd24,6'd25,6'd26,6'd27,6'd28, 6'd27,6'd28,6'd29,6'd30,6'd31,6'd0};
	localparam logic [4:0] TabP [32] = '{
		5'd15,5'd6,5'd19,5'd20,5'd28,5'd11,5'd27,5'd16,
		5'd0,5'd14,5'd22,5'd25,5'd4,5'd17,5'd30,5'd9,
		5'd1,5'd7,5'd23,5'd13,5'd31,5'd26,5'd2,5'd8,
		5'd18,5'd12,5'd29,5'd5,5'd21,5'd10,5'd3,5'd24};
	localparam logic [5:0] TabPc1 [56] = '{
		6'd56,6'd48,6'd40,6'd32,6'd24,6'd16,6'd8, 6'd0,6'd57,6'd49,6'd41,6'd33,6'd25,6'd17,
		6'd9,6'd1,6'd58,6'd50,6'd42,6'd34,6'd26, 6'd18,6'd10,6'd2,6'd59,6'd51,6'd43,6'd35,
		6'd62,6'd54,6'd46,6'd38,6'd30,6'd22,6'd14, 6'd6,6'd61,6'd53,6'd45,6'd37,6'd29,6'd21,
		6'd13,6'd5,6'd60,6'd52,6'd44,6'd36,6'd28, 6'd20,6'd12,6'd4,6'd27,6'd19,6'd11,6'd3};
	localparam logic [5:0] TabPc2 [48] = '{
		6'd13,6'd16,6'd10,6'd23,6'd0,6'd4, 6'd2,6'd27,6'd14,6'd5,6'd20,6'd9,
		6'd22,6'd18,6'd11,6'd3,6'd25,6'd7, 6'd15,6'd6,6'd26,6'd19,6'd12,6'd1,
		6'd40,6'd51,6'd30,6'd36,6'd46,6'd54, 6'd29,6'd39,6'd50,6'd44,6'd32,6'd47,
		6'd43,6'd48,6'd38,6'd55,6'd33,6'd52, 6'd45,6'd41,6'd49,6'd35,6'd28,6'd31};
	// bit 15 is round 0
	localparam logic [15:0] DoubleRot = 16'b0011111101111110;

	localparam logic [3:0] Sbox [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

	// tables count bits from the top, zero based
	function automatic logic [63:0] perm64(input logic [63:0] v, input ptab_t tab);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = v[63-tab[i]];
		return r;
	endfunction

	function automatic logic [55:0] pc1(input logic [63:0] k);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = k[63-TabPc1[i]];
		return r;
	endfunction

	function automatic logic [47:0] pc2(input logic [55:0] cd);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = cd[55-TabPc2[i]];
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
		logic [47:0] e;
		logic [5:0] six;
		logic [31:0] s;
		logic [31:0] p;
		for (int i = 0; i < 48; i++) e[47-i] = r[31-TabE[i]];
		e = e ^ k;
		for (int i = 0; i < 8; i++) begin
			six = e[47-6*i -: 6];
			s[31-4*i -: 4] = Sbox[i][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[31-TabP[i]];
		return p;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/dcc_if.sv -----
// valid/ready stream interface carrying a generic payload type
// depends on nothing
`default_nettype none
interface dcc_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/dcc_key_sched.sv -----
// key schedule: c/d halves rotated one round per cycle alongside the rounds
// depends on dcc_pkg
`default_nettype none
module dcc_key_sched import dcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [63:0] key,
	input  wire logic        load,
	input  wire logic        dec,
	input  wire logic        step,
	input  wire logic [RndW-1:0] rnd,
	output logic [KeyW-1:0]  round_key
);
	logic [27:0] c_q, d_q;
	logic [55:0] cd0;
	logic [27:0] c_n, d_n;
	logic two;

	assign cd0 = pc1(key);
	// encrypt rotates left before use, decrypt rotates right after use
	always_comb begin
		two = DoubleRot[~rnd];
		if (!dec) begin
			c_n = two ? {c_q[25:0], c_q[27:26]} : {c_q[26:0], c_q[27]};
			d_n = two ? {d_q[25:0], d_q[27:26]} : {d_q[26:0], d_q[27]};
		end else begin
			c_n = c_q;
			d_n = d_q;
		end
		round_key = pc2({c_n, d_n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			d_q <= '0;
		end else if (load) begin
			c_q <= cd0[55:28];
			d_q <= cd0[27:0];
		end else if (step) begin
			if (!dec) begin
				c_q <= c_n;
				d_q <= d_n;
			end else begin
				// decrypt key i uses total rotation of round 15-i; undo that round's shift
				c_q <= DoubleRot[rnd] ? {c_q[1:0], c_q[27:2]} : {c_q[0], c_q[27:1]};
				d_q <= DoubleRot[rnd] ? {d_q[1:0], d_q[27:2]} : {d_q[0], d_q[27:1]};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/des_cbc_cipher_top.sv -----
// DES in CBC mode over 64-bit requests, encrypting or decrypting as the mode register
// says, with key and iv set through the config write port. A request is accepted only
// while the engine is idle; it takes a load step and sixteen rounds in the single
// shared round unit, so the next request is accepted only once its result has been
// written to the output register, where it sits; so a result waiting to be taken does
// not hold off the next request, and a later result that finds that register still
// full waits in the done state, and the input stays not ready until it moves out.
// Config writes only while idle.
// depends on dcc_pkg, dcc_key_sched and des_cbc_cipher_top_defines.svh
`default_nettype none
`include "des_cbc_cipher_top_defines.svh"
module des_cbc_cipher_top import dcc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic [63:0] in_data_block,
	input  wire logic in_first_block,
	input  wire logic [63:0] in_packet_vector,
	input  wire logic in_valid,
	output logic in_ready,
	output logic [63:0] out_result_block,
	output logic [63:0] out_vector_used,
	output logic out_valid,
	input  wire logic out_ready
);
	typedef enum logic [3:0] {
		StIdle = 4'b0001, StLoad = 4'b0010, StRound = 4'b0100, StDone = 4'b1000
	} state_t;
	state_t state_q;
	logic dec_q;
	logic [63:0] key_q, chain_q, psv_q, blk_q;
	logic [31:0] l_q, r_q;
	logic [RndW-1:0] rnd_q;
	logic [KeyW-1:0] rk;
	logic [63:0] pre, fin, fp_in, res_blk;
	logic [31:0] f_out;
	logic out_load;

	dcc_key_sched u_ks (
		.clk, .arst_n, .key(key_q), .load(state_q == StLoad), .dec(dec_q),
		.step(state_q == StRound), .rnd(rnd_q), .round_key(rk)
	);

	assign in_ready = (state_q == StIdle);
	assign pre = perm64(dec_q ? blk_q : (blk_q ^ chain_q), TabIp);
	assign f_out = l_q ^ feistel(r_q, rk);
	// last round's output straight from the round unit, or held in the done state
	assign fp_in = (state_q == StDone) ? {r_q, l_q} : {f_out, r_q};
	assign fin = perm64(fp_in, TabFp);
	assign res_blk = dec_q ? (fin ^ chain_q) : fin;
	assign out_load = (!out_valid || out_ready) &&
		((state_q == StRound && rnd_q == RndW'(Rounds - 1)) || state_q == StDone);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			dec_q <= 1'b0;
			key_q <= '0;
			chain_q <= '0;
			psv_q <= '0;
			blk_q <= '0;
			l_q <= '0;
			r_q <= '0;
			out_valid <= 1'b0;
			out_result_block <= '0;
			out_vector_used <= '0;
			rnd_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgMode: dec_q <= cfg_data[0];
					CfgKey: key_q <= cfg_data;
					CfgIv: chain_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid <= 1'b1;
				out_result_block <= res_blk;
				out_vector_used <= psv_q;
				chain_q <= dec_q ? blk_q : fin;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				StIdle: if (in_valid) begin
					blk_q <= in_data_block;
					if (in_first_block) begin
						if (dec_q) begin
							chain_q <= in_packet_vector;
							psv_q <= in_packet_vector;
						end else psv_q <= chain_q;
					end
					state_q <= StLoad;
				end
				StLoad: begin
					l_q <= pre[63:32];
					r_q <= pre[31:0];
					rnd_q <= '0;
					state_q <= StRound;
				end
				StRound: begin
					l_q <= r_q;
					r_q <= f_out;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RndW'(Rounds - 1)) begin
						state_q <= out_load ? StIdle : StDone;
					end
				end
				StDone: begin
					if (out_load) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`DCC_ASSERT_NEXT(a_acc_load, clk, arst_n, in_valid && in_ready, state_q == StLoad)
	`DCC_ASSERT_NEXT(a_load_round, clk, arst_n, state_q == StLoad, state_q == StRound && rnd_q == '0)
	`DCC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_result_block))
	`DCC_ASSERT_IMP(a_done_valid, clk, arst_n, state_q == StDone, out_valid)
endmodule
`default_nettype wire

// ----- tb/dcc_tb_pkg.sv -----
// request and result payload types for the des cbc cipher testbench
// no dependencies
package dcc_tb_pkg;
	typedef struct packed {
		logic [63:0] data_block;
		logic first_block;
		logic [63:0] packet_vector;
	} req_item_t;

	typedef struct packed {
		logic [63:0] result_block;
		logic [63:0] vector_used;
	} res_item_t;
endpackage

// ----- tb/dcc_checker.sv -----
// watches config writes and both streams of the des cbc cipher, predicts each result
// with its own des/cbc model and compares; depends on dcc_pkg and dcc_tb_pkg
module dcc_checker import dcc_pkg::*; import dcc_tb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  req_item_t req_data,
	input  wire logic res_valid,
	input  wire logic res_ready,
	input  res_item_t res_data,
	output int pending,
	output int errors,
	output int matched
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IpT [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
	localparam int FpT [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
	localparam int ExpT [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
	localparam int PermT [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
	localparam int Pc1T [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
	localparam int Pc2T [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
	localparam int ShiftTwo [16] = '{0,0,1,1,1,1,1,1,0,1,1,1,1,1,1,0};
	localparam int SubT [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	logic decrypting;
	logic [63:0] chain_reg;
	logic [63:0] pkt_iv;
	logic [47:0] subkeys [16];
	res_item_t cipher_fifo [$];

	function automatic void load_subkeys(input logic [63:0] key);
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		logic [55:0] cdr;
		int k;
		for (int i = 0; i < 56; i++) cd[55-i] = key[64-Pc1T[i]];
		c = cd[55:28];
		d = cd[27:0];
		for (int r = 0; r < 16; r++) begin
			k = 1 + ShiftTwo[r];
			c = (c << k) | (c >> (28 - k));
			d = (d << k) | (d >> (28 - k));
			cdr = {c, d};
			for (int i = 0; i < 48; i++) subkeys[r][47-i] = cdr[56-Pc2T[i]];
		end
	endfunction

	function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] k);
		logic [47:0] e;
		logic [5:0] six;
		logic [31:0] s;
		logic [31:0] p;
		for (int i = 0; i < 48; i++) e[47-i] = r[32-ExpT[i]];
		e = e ^ k;
		for (int i = 0; i < 8; i++) begin
			six = e[47-6*i -: 6];
			s[31-4*i -: 4] = SubT[i][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-PermT[i]];
		return p;
	endfunction

	function automatic logic [63:0] des_crypt(input logic [63:0] blk, input logic dec);
		logic [63:0] v;
		logic [63:0] o;
		logic [63:0] q;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		for (int i = 0; i < 64; i++) v[63-i] = blk[64-IpT[i]];
		l = v[63:32];
		r = v[31:0];
		for (int i = 0; i < 16; i++) begin
			t = r;
			r = l ^ round_fn(r, subkeys[dec ? 15 - i : i]);
			l = t;
		end
		q = {r, l};
		for (int i = 0; i < 64; i++) o[63-i] = q[64-FpT[i]];
		return o;
	endfunction

	initial begin
		decrypting = 1'b0;
		chain_reg = '0;
		pkt_iv = '0;
		errors = 0;
		matched = 0;
		load_subkeys('0);
	end

	assign pending = cipher_fifo.size();

	always @(posedge clk) begin
		res_item_t exp_item;
		res_item_t got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CfgMode: decrypting = cfg_data[0];
					CfgKey: load_subkeys(cfg_data);
					CfgIv: chain_reg = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (decrypting) begin
					if (req_data.first_block) begin
						chain_reg = req_data.packet_vector;
						pkt_iv = req_data.packet_vector;
					end
					exp_item.result_block = des_crypt(req_data.data_block, 1'b1) ^ chain_reg;
					chain_reg = req_data.data_block;
				end else begin
					if (req_data.first_block) pkt_iv = chain_reg;
					exp_item.result_block = des_crypt(req_data.data_block ^ chain_reg, 1'b0);
					chain_reg = exp_item.result_block;
				end
				exp_item.vector_used = pkt_iv;
				cipher_fifo.push_back(exp_item);
			end
			if (res_valid && res_ready) begin
				got = res_data;
				if (cipher_fifo.size() == 0) begin
					$error("unexpected result %h / %h", got.result_block, got.vector_used);
					errors++;
				end else begin
					exp_item = cipher_fifo.pop_front();
					if (got.result_block !== exp_item.result_block) begin
						$error("result_block expected %h actual %h",
							exp_item.result_block, got.result_block);
						errors++;
					end
					if (got.vector_used !== exp_item.vector_used) begin
						$error("vector_used expected %h actual %h",
							exp_item.vector_used, got.vector_used);
						errors++;
					end
					matched++;
				end
			end
		end
	end
endmodule

// ----- tb/des_cbc_cipher_top_test.sv -----
// stimulus and verdict for the des cbc cipher: config phases, directed and random requests
// depends on dcc_pkg, dcc_if, dcc_tb_pkg, dcc_checker and des_cbc_cipher_top
module des_cbc_cipher_top_test;
	import dcc_pkg::*;
	import dcc_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CfgMode;
	logic [63:0] cfg_data = '0;
	logic steady = 1'b0;
	int cycles = 0;
	int pending;
	int errors;
	int matched;
	int cfg_writes = 0;
	int sent = 0;

	dcc_if #(.payload_t(req_item_t)) req_ch ();
	dcc_if #(.payload_t(res_item_t)) res_ch ();

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	des_cbc_cipher_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data_block(req_ch.data.data_block),
		.in_first_block(req_ch.data.first_block),
		.in_packet_vector(req_ch.data.packet_vector),
		.in_valid(req_ch.valid),
		.in_ready(req_ch.ready),
		.out_result_block(res_ch.data.result_block),
		.out_vector_used(res_ch.data.vector_used),
		.out_valid(res_ch.valid),
		.out_ready(res_ch.ready)
	);

	dcc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
		.res_valid(res_ch.valid), .res_ready(res_ch.ready), .res_data(res_ch.data),
		.pending(pending), .errors(errors), .matched(matched)
	);

	always @(negedge clk) res_ch.ready <= steady || ($urandom_range(99) >= 31);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("des_cbc_cipher_top_test: errors");
			$finish;
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] edge_val();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_writes++;
	endtask

	// enters and leaves at a falling edge with valid low
	task automatic send(input logic [63:0] blk, input logic first, input logic [63:0] pv);
		logic took;
		while (!steady && $urandom_range(99) < 31) @(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data = '{data_block: blk, first_block: first, packet_vector: pv};
		took = 1'b0;
		while (!took) begin
			#1;
			took = req_ch.ready;
			@(negedge clk);
		end
		req_ch.valid = 1'b0;
		sent++;
	endtask

	task automatic send_packet(input int len);
		logic [63:0] iv;
		iv = edge_val();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) send(rnd64(), $urandom_range(1), rnd64());
			else send(rnd64(), i == 0, i == 0 ? iv : rnd64());
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// non-first block straight after reset, then extremes at key and iv zero
		send(64'h0, 1'b0, '1);
		send('1, 1'b1, '1);
		send(64'h0123456789abcdef, 1'b0, '0);
		drain();
		cfg_write(CfgKey, 64'h133457799bbcdff1);
		cfg_write(CfgIv, '1);
		send(64'h0123456789abcdef, 1'b1, '0);
		send('0, 1'b0, '1);
		drain();
		cfg_write(CfgKey, '1);
		cfg_write(cfg_idx_t'(2'd3), 64'hdeadbeefdeadbeef);
		send('1, 1'b1, '0);
		drain();
		// upper bits of the mode write are dropped
		cfg_write(CfgMode, '1);
		send(64'h85e813540f0ab405, 1'b1, '1);
		send('0, 1'b0, '0);
		send('1, 1'b1, '0);
		send(64'h5555aaaa5555aaaa, 1'b0, '1);
		drain();
		// back to encryption without a new iv: chain carries on from the ciphertext
		cfg_write(CfgMode, 64'h2);
		send(64'h0, 1'b0, '0);
		send(64'h1, 1'b1, '1);
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			steady = (ph == 4);
			cfg_write(CfgMode, ph < 2 ? ph : $urandom_range(3));
			if ($urandom_range(1)) cfg_write(CfgKey, edge_val());
			if ($urandom_range(1)) cfg_write(CfgIv, edge_val());
			while (sent < 25 + (ph + 1) * 200) send_packet($urandom_range(1, 8));
		end
		drain();
		steady = 1'b0;
		$display("sent %0d requests, %0d results compared, %0d config writes",
			sent, matched, cfg_writes);
		if (errors == 0 && pending == 0) $display("des_cbc_cipher_top_test: clean");
		else $display("des_cbc_cipher_top_test: errors");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dcc_pkg.sv
rtl/dcc_if.sv
rtl/dcc_key_sched.sv
rtl/des_cbc_cipher_top.sv
tb/dcc_tb_pkg.sv
tb/dcc_checker.sv
tb/des_cbc_cipher_top_test.sv
